// ===== hw/rtl/hamilton_path_count_dp_assert.svh =====
// Assertion macros shared by the checker of the Hamilton path counter.
`ifndef HAMILTON_PATH_COUNT_DP_ASSERT_SVH
`define HAMILTON_PATH_COUNT_DP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define HPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define HPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/hpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hamilton path counter package
// Shared widths, controller states and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package hpc_pkg;

  localparam int CNT_W     = 80;
  localparam int LO_W      = 64;
  localparam int HI_W      = 16;
  localparam int IDX_W     = 4;
  localparam int NBR_W     = 16;
  localparam int CFG_W     = 5;
  localparam int IN_DATA_W = 24;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PICK,
    ST_SCAN,
    ST_DRAIN,
    ST_STORE,
    ST_SUM_INIT,
    ST_SUM_SCAN,
    ST_SUM_DRAIN,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic start;
    logic entry_init;
    logic sum_init;
    logic scan;
    logic store;
    logic next_v;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic v_in_s;
    logic v_last;
    logic s_full;
    logic u_last;
    logic out_busy;
  } sts_t;

endpackage

// ===== hw/rtl/hpc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hamilton path counter controller
// Sequences row loading, the subset sweep, the final sum and the result word.
// ----------------------------------------------------------------------------
module hpc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tlast,
  output logic          in_tready,
  input  hpc_pkg::sts_t sts,
  output hpc_pkg::cmd_t cmd
);

  hpc_pkg::state_t state_r;
  hpc_pkg::state_t state_nxt;
  logic            sweep_done;

  assign sweep_done = sts.v_last && sts.s_full;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hpc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hpc_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready && in_tlast) state_nxt = hpc_pkg::ST_PICK;
      end
      hpc_pkg::ST_PICK: begin
        if (sts.v_in_s) state_nxt = hpc_pkg::ST_SCAN;
        else if (sweep_done) state_nxt = hpc_pkg::ST_SUM_INIT;
      end
      hpc_pkg::ST_SCAN: begin
        if (sts.u_last) state_nxt = hpc_pkg::ST_DRAIN;
      end
      hpc_pkg::ST_DRAIN:    state_nxt = hpc_pkg::ST_STORE;
      hpc_pkg::ST_STORE: begin
        state_nxt = sweep_done ? hpc_pkg::ST_SUM_INIT : hpc_pkg::ST_PICK;
      end
      hpc_pkg::ST_SUM_INIT: state_nxt = hpc_pkg::ST_SUM_SCAN;
      hpc_pkg::ST_SUM_SCAN: begin
        if (sts.u_last) state_nxt = hpc_pkg::ST_SUM_DRAIN;
      end
      hpc_pkg::ST_SUM_DRAIN: state_nxt = hpc_pkg::ST_FINISH;
      hpc_pkg::ST_FINISH:    state_nxt = hpc_pkg::ST_IDLE;
      default:               state_nxt = hpc_pkg::ST_IDLE;
    endcase
  end

  // Outputs. A final row waits while the previous result is still held.
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      hpc_pkg::ST_IDLE: begin
        in_tready = !(sts.out_busy && in_tlast);
        cmd.load  = in_tvalid && in_tready;
        cmd.start = in_tvalid && in_tready && in_tlast;
      end
      hpc_pkg::ST_PICK: begin
        cmd.entry_init = sts.v_in_s;
        cmd.next_v     = !sts.v_in_s && !sweep_done;
      end
      hpc_pkg::ST_SCAN:     cmd.scan = 1'b1;
      hpc_pkg::ST_STORE: begin
        cmd.store  = 1'b1;
        cmd.next_v = !sweep_done;
      end
      hpc_pkg::ST_SUM_INIT: cmd.sum_init = 1'b1;
      hpc_pkg::ST_SUM_SCAN: cmd.scan = 1'b1;
      hpc_pkg::ST_FINISH:   cmd.out_load = 1'b1;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/hpc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hamilton path counter datapath
// Row store, subset and vertex counters, the count table and the accumulator.
// ----------------------------------------------------------------------------
module hpc_dp #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [hpc_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          in_tuser,
  input  logic                          cfg_wr_en,
  input  logic [hpc_pkg::CFG_W-1:0]     cfg_wr_data,
  input  hpc_pkg::cmd_t                 cmd,
  output hpc_pkg::sts_t                 sts,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [hpc_pkg::CNT_W-1:0]     out_tdata
);

  localparam int VW      = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW      = $clog2(MAX_VERTICES + 1);
  localparam int AW      = MAX_VERTICES + VW;
  localparam int VC_RST  = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;

  logic [MAX_VERTICES-1:0] adj_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] ep_r;
  logic [NW-1:0]           vc_r;
  logic [MAX_VERTICES-1:0] s_r;
  logic [VW-1:0]           v_r;
  logic [VW-1:0]           u_r;
  logic                    sum_mode_r;
  logic                    iss_vld_r;
  logic [hpc_pkg::CNT_W-1:0] acc_r;
  logic [hpc_pkg::CNT_W-1:0] rd_data_r;
  logic [hpc_pkg::CNT_W-1:0] mem [2**AW];
  logic                      out_vld_r;
  logic [hpc_pkg::CNT_W-1:0] out_data_r;

  logic [hpc_pkg::IDX_W-1:0] in_idx;
  logic [hpc_pkg::NBR_W-1:0] in_nbr;
  logic [MAX_VERTICES-1:0]   full_mask;
  logic [MAX_VERTICES-1:0]   rest;
  logic [MAX_VERTICES-1:0]   subset;
  logic [MAX_VERTICES-1:0]   pred_mask;
  logic [NW-1:0]             n_last;
  logic                      base_bit;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;

  assign in_idx = in_tdata[hpc_pkg::IDX_W-1:0];
  assign in_nbr = in_tdata[hpc_pkg::IDX_W +: hpc_pkg::NBR_W];

  // Subset and mask decode.
  assign full_mask = ~({MAX_VERTICES{1'b1}} << vc_r);
  assign rest      = s_r & ~(MAX_VERTICES'(1) << v_r);
  assign subset    = sum_mode_r ? full_mask : rest;
  assign pred_mask = sum_mode_r ? (ep_r & full_mask) : (adj_r[v_r] & rest & full_mask);
  assign n_last    = vc_r - NW'(1);
  assign base_bit  = (rest == '0) && ep_r[v_r];
  assign rd_addr   = {subset, u_r};
  assign wr_addr   = {s_r, v_r};

  assign sts.v_in_s   = s_r[v_r];
  assign sts.v_last   = (NW'(v_r) == n_last);
  assign sts.s_full   = (s_r == full_mask);
  assign sts.u_last   = (NW'(u_r) == n_last);
  assign sts.out_busy = out_vld_r;

  // Vertex count register with saturation into the supported range.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= NW'(VC_RST);
    end else if (cfg_wr_en) begin
      if (cfg_wr_data == '0) vc_r <= NW'(1);
      else if (32'(cfg_wr_data) > MAX_VERTICES) vc_r <= NW'(MAX_VERTICES);
      else vc_r <= NW'(cfg_wr_data);
    end
  end

  // Endpoint permit bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ep_r <= '0;
    end else if (cmd.load && (32'(in_idx) < MAX_VERTICES)) begin
      ep_r[VW'(in_idx)] <= in_tuser;
    end
  end

  // Adjacency rows; rows for indexes at or above MAX_VERTICES are dropped.
  always_ff @(posedge clk) begin
    if (cmd.load && (32'(in_idx) < MAX_VERTICES)) begin
      adj_r[VW'(in_idx)] <= MAX_VERTICES'(in_nbr);
    end
  end

  // Subset and vertex counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
      v_r <= '0;
    end else if (cmd.start) begin
      s_r <= MAX_VERTICES'(1);
      v_r <= '0;
    end else if (cmd.next_v) begin
      if (sts.v_last) begin
        v_r <= '0;
        s_r <= s_r + MAX_VERTICES'(1);
      end else begin
        v_r <= v_r + VW'(1);
      end
    end
  end

  // Predecessor scan: one table read issued per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_r        <= '0;
      sum_mode_r <= 1'b0;
      iss_vld_r  <= 1'b0;
    end else begin
      iss_vld_r <= cmd.scan && pred_mask[u_r];
      if (cmd.entry_init || cmd.sum_init) begin
        u_r        <= '0;
        sum_mode_r <= cmd.sum_init;
      end else if (cmd.scan) begin
        u_r <= u_r + VW'(1);
      end
    end
  end

  // Accumulator: a registered read lands in the cycle after its issue.
  always_ff @(posedge clk) begin
    if (cmd.entry_init) begin
      acc_r <= hpc_pkg::CNT_W'(base_bit);
    end else if (cmd.sum_init) begin
      acc_r <= '0;
    end else if (iss_vld_r) begin
      acc_r <= acc_r + rd_data_r;
    end
  end

  // Count table: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[wr_addr] <= acc_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= acc_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/hamilton_path_count_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hamilton path counter
// Held-Karp subset sweep counting oriented Hamilton paths with permitted ends.
// ----------------------------------------------------------------------------
// Each input word loads one adjacency row. The word marked tlast starts a
// count over the first n vertices (n = the configured vertex total), which
// runs on a table memory with one read port: per subset, each member vertex
// is scanned over all n candidate predecessors before its count is stored,
// and each non-member vertex is skipped. A step from u to v is allowed when
// bit u of row v is set. No input is taken during the count; rows (but not
// a final row) are taken while a result waits.
module hamilton_path_count_dp #(
  parameter int MAX_VERTICES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: vertex_index [3:0], neighbor_mask [19:4], zero fill [23:20].
  input  logic [23:0] in_tdata,
  // in_tuser: endpoint_ok.
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: count_low [63:0], count_high [79:64].
  output logic [79:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  hpc_pkg::cmd_t cmd;
  hpc_pkg::sts_t sts;

  // Sequencer.
  hpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and arithmetic.
  hpc_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata)
  );

endmodule

// ===== hw/rtl/hpc_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hamilton path counter checker
// Port-level checks of the handshakes around a count.
// ----------------------------------------------------------------------------
`include "hamilton_path_count_dp_assert.svh"

module hpc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tlast,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [79:0] out_tdata,
  input logic        out_tvalid,
  input logic        out_tready
);

  // A held result word stays put until taken.
  `HPC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result word changed while stalled")

  // A final row is refused while an earlier result is still waiting.
  `HPC_ASSERT_NOW(a_last_blocked, out_tvalid && in_tvalid && in_tlast, !in_tready, "final row taken over a pending result")

  // Once a count starts, the input side closes.
  `HPC_ASSERT_NEXT(a_busy_after_last, in_tvalid && in_tready && in_tlast, !in_tready, "input open right after a final row")

  // A result appears only at the end of a count, when input was closed.
  `HPC_ASSERT_NOW(a_result_from_count, $rose(out_tvalid), !$past(in_tready), "result appeared outside a count")

endmodule

bind hamilton_path_count_dp hpc_chk u_hpc_chk (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hamilton path counter testbench
// Loads adjacency rows, triggers counts over small vertex sets and checks each
// count word against a typed value or a subset-sweep predictor, under random stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_V       = 16;
  localparam int TBL_SETS    = 4096;   // enough for counts up to 12 vertices
  localparam int WATCH_LIMIT = 1500000;
  localparam int SETTLE      = 40;

  logic                            clk;
  logic                            rst_n;
  logic [hpc_pkg::IN_DATA_W-1:0]   in_tdata;
  logic                            in_tuser;
  logic                            in_tlast;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [hpc_pkg::CNT_W-1:0]       out_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic                            cfg_wr_en;
  logic [hpc_pkg::CFG_W-1:0]       cfg_wr_data;

  hamilton_path_count_dp #(.MAX_VERTICES(MAX_V)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tlast(in_tlast),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Free-running clock, 20 ns period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the block's state.
  logic [hpc_pkg::NBR_W-1:0] adj_rows [0:MAX_V-1];
  logic [MAX_V-1:0]          end_permit;
  int                        used_vertices;
  logic [hpc_pkg::CNT_W-1:0] path_tbl [0:TBL_SETS-1][0:MAX_V-1];

  logic [hpc_pkg::CNT_W-1:0] count_q [$];
  int  errors;
  int  words_sent;
  int  counts_seen;
  int  tx_idle_pct;
  int  rx_idle_pct;
  int  rx_hold_left;
  int  quiet_cycles;
  bit  typed_valid;
  logic [hpc_pkg::CNT_W-1:0] typed_count;

  typedef struct {
    int                        cfg;      // -1 leaves the register alone
    logic [hpc_pkg::IDX_W-1:0] idx;
    logic [hpc_pkg::NBR_W-1:0] mask;
    bit                        ok;
    bit                        last;
    bit                        known;
    logic [hpc_pkg::CNT_W-1:0] value;
  } stim_row_t;

  stim_row_t dir_rows [$];

  // Oriented Hamilton paths over the used vertices with permitted ends.
  function automatic logic [hpc_pkg::CNT_W-1:0] count_paths();
    int full;
    int rest;
    logic [hpc_pkg::CNT_W-1:0] acc;
    logic [hpc_pkg::CNT_W-1:0] total;
    full = (1 << used_vertices) - 1;
    for (int s = 1; s <= full; s++) begin
      for (int v = 0; v < used_vertices; v++) begin
        if (s[v]) begin
          rest = s & ~(1 << v);
          if (rest == 0) begin
            acc = hpc_pkg::CNT_W'(end_permit[v]);
          end else begin
            acc = '0;
            for (int u = 0; u < used_vertices; u++)
              if (adj_rows[v][u] && rest[u]) acc = acc + path_tbl[rest][u];
          end
          path_tbl[s][v] = acc;
        end
      end
    end
    total = '0;
    for (int v = 0; v < used_vertices; v++)
      if (end_permit[v]) total = total + path_tbl[full][v];
    return total;
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [hpc_pkg::CNT_W-1:0] got,
                                 input logic [hpc_pkg::CNT_W-1:0] want);
    $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // Input-side prediction and result checking, both on the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        adj_rows[in_tdata[3:0]]   = in_tdata[19:4];
        end_permit[in_tdata[3:0]] = in_tuser;
        if (in_tlast) count_q.push_back(typed_valid ? typed_count : count_paths());
      end
      if (out_tvalid && out_tready) begin
        counts_seen++;
        if (count_q.size() == 0) begin
          report_mismatch("count word with none expected", out_tdata, '0);
        end else begin
          if (out_tdata[63:0] !== count_q[0][63:0])
            report_mismatch("count_low", hpc_pkg::CNT_W'(out_tdata[63:0]),
                            hpc_pkg::CNT_W'(count_q[0][63:0]));
          if (out_tdata[79:64] !== count_q[0][79:64])
            report_mismatch("count_high", hpc_pkg::CNT_W'(out_tdata[79:64]),
                            hpc_pkg::CNT_W'(count_q[0][79:64]));
          void'(count_q.pop_front());
        end
      end
      // Watchdog on cycles with no word moving on either side.
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("Watchdog expired with %0d counts pending.", count_q.size());
        $display("hamilton_path_count_dp: mismatch");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready = 1'b0;
    end else if (rx_hold_left > 0) begin
      out_tready = 1'b0;
      rx_hold_left--;
    end else begin
      out_tready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic set_idling();
    if (words_sent < 350) begin
      tx_idle_pct = 38; rx_idle_pct = 72;
    end else if (words_sent < 700) begin
      tx_idle_pct = 72; rx_idle_pct = 38;
    end else begin
      tx_idle_pct = 0; rx_idle_pct = 0;
    end
  endtask

  // Drive one row word and hold it until it is taken.
  task automatic send_row(input logic [hpc_pkg::IDX_W-1:0] idx,
                          input logic [hpc_pkg::NBR_W-1:0] mask,
                          input bit ok, input bit last);
    set_idling();
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = {4'b0, mask, idx};
    in_tuser  = ok;
    in_tlast  = last;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
    words_sent++;
  endtask

  // Let all counts drain, then allow the block to settle.
  task automatic wait_drained();
    while (count_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_vertex_total(input int value);
    wait_drained();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value[hpc_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    used_vertices = (value == 0) ? 1 : (value > MAX_V) ? MAX_V : value;
  endtask

  task automatic add_row(input int cfg, input logic [hpc_pkg::IDX_W-1:0] idx,
                         input logic [hpc_pkg::NBR_W-1:0] mask, input bit ok,
                         input bit last, input bit known,
                         input logic [hpc_pkg::CNT_W-1:0] value);
    stim_row_t r;
    r.cfg = cfg; r.idx = idx; r.mask = mask; r.ok = ok; r.last = last;
    r.known = known; r.value = value;
    dir_rows.push_back(r);
  endtask

  initial begin
    int n;
    int frame_len;
    int frames;
    logic [hpc_pkg::IDX_W-1:0] idx;
    logic [hpc_pkg::NBR_W-1:0] mask;

    errors = 0; words_sent = 0; counts_seen = 0; quiet_cycles = 0;
    rx_hold_left = 0; tx_idle_pct = 0; rx_idle_pct = 0;
    typed_valid = 1'b0; typed_count = '0;
    end_permit = '0; used_vertices = MAX_V;
    for (int i = 0; i < MAX_V; i++) adj_rows[i] = '0;
    in_tdata = '0; in_tuser = 1'b0; in_tlast = 1'b0; in_tvalid = 1'b0;
    cfg_wr_en = 1'b0; cfg_wr_data = '0;

    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table: every row loaded once, then the special cases.
    for (int i = 0; i < MAX_V; i++)
      add_row(-1, hpc_pkg::IDX_W'(i), 16'hFFFF, 1'b1, 1'b0, 1'b0, '0);
    add_row(0,  4'd0, 16'h0000, 1'b1, 1'b1, 1'b1, 80'd1);  // zero register acts as one vertex
    add_row(1,  4'd0, 16'hFFFF, 1'b0, 1'b1, 1'b1, 80'd0);  // lone vertex not permitted
    add_row(2,  4'd0, 16'hFFFF, 1'b1, 1'b1, 1'b1, 80'd2);  // one edge, both directions
    add_row(31, 4'd3, 16'h0000, 1'b1, 1'b0, 1'b0, '0);     // saturates to the maximum
    add_row(5,  4'd2, 16'h0000, 1'b1, 1'b1, 1'b0, '0);     // one vertex with no predecessors
    add_row(12, 4'd5, 16'hFFFF, 1'b1, 1'b1, 1'b0, '0);     // largest count in the run
    add_row(3,  4'd1, 16'h0005, 1'b1, 1'b1, 1'b0, '0);     // row reload

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg >= 0) write_vertex_total(dir_rows[i].cfg);
      typed_valid = dir_rows[i].known;
      typed_count = dir_rows[i].value;
      send_row(dir_rows[i].idx, dir_rows[i].mask, dir_rows[i].ok, dir_rows[i].last);
    end
    typed_valid = 1'b0;

    // Random frames: a handful of rows, the last one starting a count.
    frames = 0;
    n = used_vertices;
    while (words_sent < 1000) begin
      if (frames % 4 == 0) begin
        case ($urandom_range(19))
          0:       n = 0;
          1, 2:    n = $urandom_range(8, 7);
          default: n = $urandom_range(6, 1);
        endcase
        write_vertex_total(n);
        n = used_vertices;
      end
      if (frames == 30) rx_hold_left = 3000;
      if (frames == 45) wait_drained();
      frame_len = $urandom_range(n + 3, 1);
      for (int k = 0; k < frame_len; k++) begin
        idx = ($urandom_range(4) == 0) ? hpc_pkg::IDX_W'($urandom_range(15))
                                       : hpc_pkg::IDX_W'($urandom_range(n - 1));
        mask = hpc_pkg::NBR_W'($urandom());
        if ($urandom_range(2) == 0) mask = mask | 16'hFFFF;
        send_row(idx, mask, $urandom_range(3) != 0, k == frame_len - 1);
      end
      frames++;
    end

    wait_drained();
    $display("Sent %0d row words in %0d random frames; checked %0d counts.",
             words_sent, frames, counts_seen);
    $display("Vertex counts from one to twelve, with stalls on both sides.");
    if (errors == 0) begin
      $display("hamilton_path_count_dp: match");
    end else begin
      $display("hamilton_path_count_dp: mismatch");
    end
    $finish;
  end

endmodule
